// ----- rtl/ertp_pkg.sv -----
// ----------------------------------------------------------------------------
// ertp_pkg: shared types and constants of the event record text parser
// Word formats, line state, configuration and character codes.
// ----------------------------------------------------------------------------
package ertp_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2
  } parse_status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_SENSOR_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_SENSOR_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_POLARITY_COUNT = 2'd2;

  localparam logic [15:0] SENSOR_WIDTH_RST   = 16'd640;
  localparam logic [15:0] SENSOR_HEIGHT_RST  = 16'd480;
  localparam logic [7:0]  POLARITY_COUNT_RST = 8'd2;

  // character codes
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // largest accumulator that can still take one more digit
  localparam logic [63:0] ACC_LIMIT_DIV10 = 64'd1844674407370955161;
  localparam logic [3:0]  ACC_LIMIT_DIGIT = 4'd5;

  // field positions
  localparam logic [2:0] FIELD_TIME     = 3'd0;
  localparam logic [2:0] FIELD_X        = 3'd1;
  localparam logic [2:0] FIELD_Y        = 3'd2;
  localparam logic [2:0] FIELD_POLARITY = 3'd3;
  localparam logic [2:0] FIELD_DONE     = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    parse_status_e parse_status;
    logic [63:0]   event_time;
    logic [15:0]   event_x;
    logic [15:0]   event_y;
    logic [7:0]    event_polarity;
  } out_word_t;

  typedef struct packed {
    logic [15:0] sensor_width;
    logic [15:0] sensor_height;
    logic [7:0]  polarity_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  field_number;
    logic        in_digits;
    logic        line_bad;
    logic [63:0] acc;
    logic        acc_ovf;
    logic [63:0] held_time;
    logic [15:0] held_x;
    logic [15:0] held_y;
  } line_state_t;

endpackage

// ----- rtl/ertp_step.sv -----
// ----------------------------------------------------------------------------
// ertp_step: one character step of the record parser
// Next line state and the line result for one input word.
// ----------------------------------------------------------------------------
module ertp_step (
  input  ertp_pkg::in_word_t    word_i,
  input  ertp_pkg::line_state_t st_i,
  input  ertp_pkg::cfg_t        cfg_i,
  output ertp_pkg::line_state_t st_o,
  output ertp_pkg::out_word_t   res_o
);
  import ertp_pkg::*;

  logic        is_digit;
  logic        is_blank;
  logic [3:0]  digit;
  logic [63:0] acc_base;
  logic        ovf_base;
  logic        do_close;
  line_state_t st_d;

  // character classes
  assign is_digit = (word_i.text_byte >= CHAR_ZERO) && (word_i.text_byte <= CHAR_NINE);
  assign is_blank = (word_i.text_byte == CHAR_SPACE) ||
                    ((word_i.text_byte >= CHAR_TAB) && (word_i.text_byte <= CHAR_CR));
  assign digit    = word_i.text_byte[3:0];

  // a fresh number starts from zero
  assign acc_base = st_i.in_digits ? st_i.acc : 64'd0;
  assign ovf_base = st_i.in_digits ? st_i.acc_ovf : 1'b0;

  always_comb begin
    st_d     = st_i;
    do_close = 1'b0;
    res_o    = '0;
    res_o.parse_status = STATUS_INVALID;

    // byte of the line
    if (!word_i.line_end) begin
      if (!st_i.line_bad) begin
        if (is_blank) begin
          do_close = st_i.in_digits;
        end else if (is_digit) begin
          if (!st_i.in_digits && (st_i.field_number >= FIELD_DONE)) begin
            st_d.line_bad = 1'b1;
          end else begin
            st_d.in_digits = 1'b1;
            st_d.acc       = acc_base;
            st_d.acc_ovf   = ovf_base;
            if (!ovf_base) begin
              if ((acc_base > ACC_LIMIT_DIV10) ||
                  ((acc_base == ACC_LIMIT_DIV10) && (digit > ACC_LIMIT_DIGIT))) begin
                st_d.acc_ovf = 1'b1;
              end else begin
                st_d.acc = (acc_base << 3) + (acc_base << 1) + {60'd0, digit};
              end
            end
          end
        end else begin
          st_d.line_bad = 1'b1;
        end
      end
    end else begin
      do_close = !st_i.line_bad && st_i.in_digits;
    end

    // close the number in progress
    if (do_close) begin
      st_d.in_digits = 1'b0;
      if (st_d.acc_ovf) begin
        st_d.line_bad = 1'b1;
      end else begin
        unique case (st_d.field_number)
          FIELD_TIME: st_d.held_time = st_d.acc;
          FIELD_X: begin
            if (st_d.acc >= {48'd0, cfg_i.sensor_width}) st_d.line_bad = 1'b1;
            else st_d.held_x = st_d.acc[15:0];
          end
          FIELD_Y: begin
            if (st_d.acc >= {48'd0, cfg_i.sensor_height}) st_d.line_bad = 1'b1;
            else st_d.held_y = st_d.acc[15:0];
          end
          FIELD_POLARITY: begin
            if (st_d.acc >= {56'd0, cfg_i.polarity_count}) st_d.line_bad = 1'b1;
          end
          default: st_d.line_bad = 1'b1;
        endcase
        if (st_d.field_number < FIELD_DONE) st_d.field_number = st_d.field_number + 3'd1;
      end
    end

    // terminator: build the result and start a new line
    if (word_i.line_end) begin
      if (!st_d.line_bad) begin
        if ((st_d.field_number == FIELD_TIME) && !st_d.in_digits) begin
          res_o.parse_status = STATUS_EMPTY;
        end else if (st_d.field_number == FIELD_DONE) begin
          res_o.parse_status   = STATUS_OK;
          res_o.event_time     = st_d.held_time;
          res_o.event_x        = st_d.held_x;
          res_o.event_y        = st_d.held_y;
          res_o.event_polarity = st_d.acc[7:0];
        end
      end
      st_d.field_number = FIELD_TIME;
      st_d.in_digits    = 1'b0;
      st_d.line_bad     = 1'b0;
      st_d.acc_ovf      = 1'b0;
    end
  end

  assign st_o = st_d;

endmodule

// ----- rtl/event_record_text_parser_unit.sv -----
// ----------------------------------------------------------------------------
// event_record_text_parser_unit: streaming event record text parser
// Parses a line of four decimal fields a byte per word, one result per line.
// ----------------------------------------------------------------------------
// channel  direction  ports                            word
// in       sink       in_valid_i in_stall_o in_word_i  text_byte, line_end
// out      source     out_valid_o out_stall_i out_word_o status and event fields
// cfg      sink       cfg_we_i cfg_idx_i cfg_data_i    register write
//
// One word per cycle is taken while no terminator is stalled; the step logic between the
// input register and the result register sets that figure. A result is written to the
// result register as its terminator is taken. Only a terminator waits in the input register while the
// result register is full and stalled; text bytes advance regardless.
// Reset clears the line state and loads the register defaults.
// ----------------------------------------------------------------------------
module event_record_text_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ertp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ertp_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import ertp_pkg::*;

  logic        in_valid_q;
  in_word_t    in_word_q;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q;
  line_state_t st_q, st_d;
  out_word_t   res;
  cfg_t        cfg_q;
  logic        advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_width   <= SENSOR_WIDTH_RST;
      cfg_q.sensor_height  <= SENSOR_HEIGHT_RST;
      cfg_q.polarity_count <= POLARITY_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSOR_WIDTH:   cfg_q.sensor_width   <= cfg_data_i;
        CFG_SENSOR_HEIGHT:  cfg_q.sensor_height  <= cfg_data_i;
        CFG_POLARITY_COUNT: cfg_q.polarity_count <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // the word in the input register moves on unless its result has no room
  assign advance    = in_valid_q && (!in_word_q.line_end || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  ertp_step u_step (
    .word_i (in_word_q),
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_word_q.line_end) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_word_q.line_end) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- tb/event_record_text_parser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// event_record_text_parser_unit_tb: self-checking bench of the record parser
// Feeds text lines a word at a time and mirrors the parser in the bench. Each
// result word is checked field by field against the predicted record. Limits
// are reprogrammed between phases. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module event_record_text_parser_unit_tb;
  import ertp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = CFG_SENSOR_WIDTH;
  logic [15:0] cfg_data  = '0;

  // stimulus and prediction
  in_word_t    pending_words[$];
  out_word_t   expected_events[$];
  logic [7:0]  line_buf[$];
  line_state_t line_st;
  cfg_t        limits;

  int queued_bytes = 0;
  int errors       = 0;
  int results_seen = 0;
  int cycles       = 0;
  int gap_max      = 0;
  int stall_pct    = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int hold_left    = 0;

  event_record_text_parser_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser mirror
  // ---------------------------------------------------------------------------
  function automatic bit is_space(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  // end the number in progress; store or bound-check it by position
  function automatic void close_number();
    line_st.in_digits = 1'b0;
    if (line_st.acc_ovf) begin
      line_st.line_bad = 1'b1;
      return;
    end
    case (line_st.field_number)
      FIELD_TIME: line_st.held_time = line_st.acc;
      FIELD_X: begin
        if (line_st.acc >= limits.sensor_width) line_st.line_bad = 1'b1;
        else line_st.held_x = line_st.acc[15:0];
      end
      FIELD_Y: begin
        if (line_st.acc >= limits.sensor_height) line_st.line_bad = 1'b1;
        else line_st.held_y = line_st.acc[15:0];
      end
      FIELD_POLARITY: begin
        if (line_st.acc >= limits.polarity_count) line_st.line_bad = 1'b1;
      end
      default: line_st.line_bad = 1'b1;
    endcase
    if (line_st.field_number < FIELD_DONE) line_st.field_number++;
  endfunction

  // advance the mirror by one accepted word; a terminator queues a record
  function automatic void parse_word(in_word_t w);
    out_word_t  res;
    logic [3:0] d;
    if (!w.line_end) begin
      if (line_st.line_bad) return;
      if (is_space(w.text_byte)) begin
        if (line_st.in_digits) close_number();
      end else if (is_digit(w.text_byte)) begin
        d = 4'(w.text_byte - CHAR_ZERO);
        if (!line_st.in_digits) begin
          // digit after the polarity field is an extra field
          if (line_st.field_number >= FIELD_DONE) begin
            line_st.line_bad = 1'b1;
            return;
          end
          line_st.in_digits = 1'b1;
          line_st.acc       = '0;
          line_st.acc_ovf   = 1'b0;
        end
        if (!line_st.acc_ovf) begin
          if (line_st.acc > ACC_LIMIT_DIV10 ||
              (line_st.acc == ACC_LIMIT_DIV10 && d > ACC_LIMIT_DIGIT))
            line_st.acc_ovf = 1'b1;
          else
            line_st.acc = line_st.acc * 64'd10 + 64'(d);
        end
      end else begin
        line_st.line_bad = 1'b1;
      end
      return;
    end

    if (!line_st.line_bad && line_st.in_digits) close_number();
    res = '0;
    res.parse_status = STATUS_INVALID;
    if (!line_st.line_bad) begin
      if (line_st.field_number == FIELD_TIME && !line_st.in_digits) begin
        res.parse_status = STATUS_EMPTY;
      end else if (line_st.field_number == FIELD_DONE) begin
        res.parse_status   = STATUS_OK;
        res.event_time     = line_st.held_time;
        res.event_x        = line_st.held_x;
        res.event_y        = line_st.held_y;
        res.event_polarity = line_st.acc[7:0];
      end
    end
    expected_events.push_back(res);
    line_st = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // line building
  // ---------------------------------------------------------------------------
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_blanks(int lo, int hi);
    repeat ($urandom_range(lo, hi)) begin
      if ($urandom_range(0, 3) == 0) line_buf.push_back(8'(CHAR_TAB + $urandom_range(0, 4)));
      else line_buf.push_back(CHAR_SPACE);
    end
  endfunction

  // decimal text, now and then with leading zeros
  function automatic void add_dec(logic [63:0] v);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(CHAR_ZERO);
    end
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_time();
    case ($urandom_range(0, 9))
      0: add_dec(64'd0);
      1: add_dec('1);
      2: begin
        // past the top in the last digit
        add_text("1844674407370955161");
        line_buf.push_back(8'(CHAR_ZERO + $urandom_range(6, 9)));
      end
      3: begin
        line_buf.push_back(8'(CHAR_ZERO + $urandom_range(1, 9)));
        repeat ($urandom_range(20, 24)) line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      4: add_dec({$urandom, $urandom});
      default: add_dec(64'($urandom));
    endcase
  endfunction

  // mostly in range, with the bound, bound - 1 and huge values mixed in
  function automatic logic [63:0] pick_value(logic [63:0] bound);
    case ($urandom_range(0, 15))
      0: return 64'd0;
      1: return bound - 64'd1;
      2: return bound;
      3: return {$urandom, $urandom};
      default: return (bound == 0) ? 64'd0 : 64'($urandom_range(0, 32'(bound - 64'd1)));
    endcase
  endfunction

  // move the built line to the send queue and close it with a terminator
  function automatic void commit_line();
    in_word_t w;
    foreach (line_buf[i]) begin
      w.text_byte = line_buf[i];
      w.line_end  = 1'b0;
      pending_words.push_back(w);
    end
    w.text_byte = 8'($urandom);
    w.line_end  = 1'b1;
    pending_words.push_back(w);
    queued_bytes += line_buf.size() + 1;
    line_buf.delete();
  endfunction

  function automatic void add_random_line();
    int         kind;
    int         n_fields;
    logic [7:0] c;
    kind     = $urandom_range(0, 99);
    n_fields = 4;
    if (kind >= 94) begin
      // raw noise over the whole byte range
      repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom));
      commit_line();
      return;
    end
    if (kind >= 88) begin
      add_blanks(0, 4);
      commit_line();
      return;
    end
    if (kind >= 75 && kind <= 80) n_fields = $urandom_range(1, 3);
    if (kind >= 81 && kind <= 84) n_fields = $urandom_range(5, 6);
    add_blanks(0, 2);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) add_blanks(1, 3);
      case (f)
        0:       add_time();
        1:       add_dec(pick_value(64'(limits.sensor_width)));
        2:       add_dec(pick_value(64'(limits.sensor_height)));
        3:       add_dec(pick_value(64'(limits.polarity_count)));
        default: add_dec(64'($urandom_range(0, 9)));
      endcase
    end
    add_blanks(0, 2);
    if (kind >= 85) begin
      // overwrite one byte with a stray character
      do c = 8'($urandom); while (is_digit(c) || is_space(c));
      line_buf[$urandom_range(0, line_buf.size() - 1)] = c;
    end
    commit_line();
  endfunction

  task automatic queue_random_lines(int n_bytes);
    int target;
    target = queued_bytes + n_bytes;
    while (queued_bytes < target) add_random_line();
  endtask

  // ---------------------------------------------------------------------------
  // phase control
  // ---------------------------------------------------------------------------
  task automatic program_limits(logic [15:0] w, logic [15:0] h, logic [7:0] p);
    logic [7:0] junk;
    junk = 8'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SENSOR_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= CFG_SENSOR_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    // upper byte is not part of the register
    cfg_idx  <= CFG_POLARITY_COUNT;
    cfg_data <= {junk, p};
    @(posedge clk);
    cfg_we <= 1'b0;
    limits.sensor_width   = w;
    limits.sensor_height  = h;
    limits.polarity_count = p;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of words with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : text_sender
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) parse_word(in_word);
      // load a new word unless one is held by a stall
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, long hold-offs to back up the input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : record_monitor
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          $error("unexpected result word, status %0d", out_word.parse_status);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("parse_status", 64'(want.parse_status), 64'(out_word.parse_status));
          check_field("event_time", want.event_time, out_word.event_time);
          check_field("event_x", 64'(want.event_x), 64'(out_word.event_x));
          check_field("event_y", 64'(want.event_y), 64'(out_word.event_y));
          check_field("event_polarity", 64'(want.event_polarity),
                      64'(out_word.event_polarity));
        end
        if (results_seen == 25 || results_seen == 50) hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** event_record_text_parser_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    limits  = {SENSOR_WIDTH_RST, SENSOR_HEIGHT_RST, POLARITY_COUNT_RST};
    line_st = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines on the reset limits, no idling
    add_text("0 0 0 0"); commit_line();
    add_text("18446744073709551615 639 479 1"); commit_line();
    add_text("18446744073709551616 0 0 0"); commit_line();
    add_text("1 640 0 0"); commit_line();
    add_text("1 0 480 0"); commit_line();
    add_text("1 0 0 2"); commit_line();
    commit_line();
    add_text(" \t\n\v\f"); line_buf.push_back(CHAR_CR); commit_line();
    add_text("\t12\t34  56"); line_buf.push_back(CHAR_CR); add_text("1 \n"); commit_line();
    add_text("1 2 3"); commit_line();
    add_text("1 2 3 1 5"); commit_line();
    add_text("1 2 31"); commit_line();
    add_text("12a 1 1 1"); commit_line();
    add_text("1 2 3 1"); line_buf.push_back(8'h00); commit_line();
    add_text("1 2 3 1"); line_buf.push_back(8'hff); commit_line();
    add_text("-1 2 3 1"); commit_line();
    add_text("99999999999999999999999 1 1 1"); commit_line();
    add_text("1 99999999999999999999 3 1"); commit_line();
    add_text("1 2 3 00000000000000000000000000001"); commit_line();
    add_text("00000000000000000000000042 5 6 1 "); commit_line();
    add_text("x 5 6 1 7 8 9"); commit_line();
    add_text("7 8 9 0"); commit_line();
    wait_idle();

    // widest limits
    gap_max = 3; stall_pct = 30;
    program_limits(16'hffff, 16'hffff, 8'hff);
    queue_random_lines(240);
    wait_idle();

    // narrowest legal limits: only zero x, y and polarity fit
    gap_max = 0; stall_pct = 0;
    program_limits(16'd1, 16'd1, 8'd1);
    queue_random_lines(240);
    wait_idle();

    // zero limits reject every record
    gap_max = 6; stall_pct = 70;
    program_limits(16'd0, 16'd0, 8'd0);
    queue_random_lines(180);
    wait_idle();

    gap_max = 2; stall_pct = 50;
    program_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 300)),
                   8'($urandom_range(1, 255)));
    queue_random_lines(290);
    wait_idle();

    gap_max = 1; stall_pct = 10;
    program_limits(SENSOR_WIDTH_RST, SENSOR_HEIGHT_RST, POLARITY_COUNT_RST);
    queue_random_lines(250);
    wait_idle();

    if (errors == 0) begin
      $display("** event_record_text_parser_unit: PASSED **");
    end else begin
      $display("** event_record_text_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
